FILE: hdl/fir16_pkg.sv
package fir16_pkg;

  // filter shape
  localparam int TAPS       = 16;
  localparam int NUM_BANKS  = 4;
  localparam int COEF_PER_BANK = 4;
  localparam int COEF_DEFINED  = NUM_BANKS * COEF_PER_BANK;

  // field and arithmetic widths
  localparam int CODE_W   = 12;
  localparam int TDATA_W  = 16;
  localparam int COEF_W   = 16;
  localparam int PROD_W   = CODE_W + COEF_W;
  localparam int GROUP_SZ = 4;
  localparam int GROUPS   = (TAPS + GROUP_SZ - 1) / GROUP_SZ;
  localparam int GRP_W    = PROD_W + $clog2(GROUP_SZ);
  localparam int ACC_W    = GRP_W + $clog2(GROUPS);
  localparam int OUT_SHIFT = 15;

  // configuration port
  localparam int BANK_W  = 64;
  localparam int IDX_W   = $clog2(NUM_BANKS);
  localparam int IDX_LSB = 3;
  localparam int ADDR_W  = IDX_W + IDX_LSB;

  typedef enum logic [IDX_W-1:0] {
    REG_COEF_A = 2'd0,
    REG_COEF_B = 2'd1,
    REG_COEF_C = 2'd2,
    REG_COEF_D = 2'd3
  } reg_idx_e;

  typedef logic signed [CODE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [GRP_W-1:0]  grp_t;
  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic [BANK_W-1:0]        bank_t;

  localparam acc_t DAC_MID = acc_t'(2048);
  localparam acc_t DAC_MAX = acc_t'(4095);

endpackage

FILE: hdl/fir16_cfg.sv
module fir16_cfg
  import fir16_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [BANK_W-1:0]   pwdata,
  output logic [BANK_W-1:0]   prdata,
  output logic                pready,
  output coef_t               coef_o [TAPS]
);

  bank_t    bank_q [NUM_BANKS];
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[ADDR_W-1:IDX_LSB]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < NUM_BANKS; b++) bank_q[b] <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_COEF_A: bank_q[0] <= pwdata;
        REG_COEF_B: bank_q[1] <= pwdata;
        REG_COEF_C: bank_q[2] <= pwdata;
        REG_COEF_D: bank_q[3] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_COEF_A: prdata = bank_q[0];
      REG_COEF_B: prdata = bank_q[1];
      REG_COEF_C: prdata = bank_q[2];
      REG_COEF_D: prdata = bank_q[3];
      default:    prdata = '0;
    endcase
  end

  // taps past the last bank weigh zero
  always_comb begin
    for (int j = 0; j < TAPS; j++) begin
      if (j < COEF_DEFINED) begin
        coef_o[j] = bank_q[j / COEF_PER_BANK][(j % COEF_PER_BANK) * COEF_W +: COEF_W];
      end else begin
        coef_o[j] = '0;
      end
    end
  end

endmodule

FILE: hdl/fir16_delay.sv
module fir16_delay
  import fir16_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [CODE_W-1:0]   code_i,
  output logic                valid_o,
  input  logic                ready_i,
  output sample_t             tap_o [TAPS]
);

  sample_t tap_q [TAPS];
  logic    valid_q;
  logic    accept;

  assign in_ready_o = !valid_q || ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // the adc code is taken as two's complement as it stands; bit 11 is not flipped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      for (int j = 0; j < TAPS; j++) tap_q[j] <= '0;
    end else begin
      if (in_ready_o) valid_q <= in_valid_i;
      if (accept) begin
        for (int j = 0; j < TAPS - 1; j++) tap_q[j] <= tap_q[j+1];
        tap_q[TAPS-1] <= sample_t'(code_i);
      end
    end
  end

  assign valid_o = valid_q;
  assign tap_o   = tap_q;

endmodule

FILE: hdl/fir16_mac.sv
module fir16_mac
  import fir16_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    valid_i,
  output logic    ready_o,
  input  sample_t tap_i  [TAPS],
  input  coef_t   coef_i [TAPS],
  output logic    valid_o,
  input  logic    ready_i,
  output acc_t    acc_o
);

  prod_t prod_q [TAPS];
  grp_t  grp_q  [GROUPS];
  grp_t  grp_d  [GROUPS];
  acc_t  acc_q;
  acc_t  acc_d;
  logic  prod_v_q, grp_v_q, acc_v_q;
  logic  rdy_prod, rdy_grp, rdy_acc;

  assign rdy_acc  = !acc_v_q  || ready_i;
  assign rdy_grp  = !grp_v_q  || rdy_acc;
  assign rdy_prod = !prod_v_q || rdy_grp;
  assign ready_o  = rdy_prod;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_v_q <= 1'b0;
      grp_v_q  <= 1'b0;
      acc_v_q  <= 1'b0;
    end else begin
      if (rdy_prod) prod_v_q <= valid_i;
      if (rdy_grp)  grp_v_q  <= prod_v_q;
      if (rdy_acc)  acc_v_q  <= grp_v_q;
    end
  end

  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      grp_d[g] = '0;
      for (int k = 0; k < GROUP_SZ; k++) begin
        if (g * GROUP_SZ + k < TAPS) begin
          grp_d[g] = grp_d[g] + grp_t'(prod_q[g * GROUP_SZ + k]);
        end
      end
    end
  end

  always_comb begin
    acc_d = '0;
    for (int g = 0; g < GROUPS; g++) acc_d = acc_d + acc_t'(grp_q[g]);
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && rdy_prod) begin
      for (int j = 0; j < TAPS; j++) prod_q[j] <= prod_t'(tap_i[j]) * prod_t'(coef_i[j]);
    end
    if (prod_v_q && rdy_grp) grp_q <= grp_d;
    if (grp_v_q && rdy_acc)  acc_q <= acc_d;
  end

  assign valid_o = acc_v_q;
  assign acc_o   = acc_q;

endmodule

FILE: hdl/fir16_out.sv
module fir16_out
  import fir16_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  acc_t              acc_i,
  output logic              valid_o,
  input  logic              ready_i,
  output logic [CODE_W-1:0] code_o
);

  acc_t              level;
  logic [CODE_W-1:0] code_d;
  logic [CODE_W-1:0] code_q;
  logic              valid_q;

  assign ready_o = !valid_q || ready_i;

  // floor shift, recenter, clamp to the converter range
  always_comb begin
    level = (acc_i >>> OUT_SHIFT) + DAC_MID;
    if (level < 0) begin
      code_d = '0;
    end else if (level > DAC_MAX) begin
      code_d = '1;
    end else begin
      code_d = level[CODE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) code_q <= code_d;
  end

  assign valid_o = valid_q;
  assign code_o  = code_q;

endmodule

FILE: hdl/fir_filter_16tap.sv
// channel      dir  handshake                 payload
// s_axis       in   s_axis_tvalid/tready      tdata[11:0] adc_code, [15:12] zero
// m_axis       out  m_axis_tvalid/tready      tdata[11:0] dac_code, [15:12] zero
// apb config   in   psel/penable/pwrite       coef banks a..d at 0x00, 0x08, 0x10, 0x18
//
// one word in and one word out per cycle when the sink keeps up
// output valid follows the input accept through five registers:
// delay line, products, four-way group sums, final sum, scale and clamp register
// each stage holds its word while the next one is full, so a stalled sink backs up
// the pipe one stage at a time before s_axis_tready drops
// reset clears the delay line, coefficients and all valid flags
module fir_filter_16tap
  import fir16_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // stream in
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [TDATA_W-1:0]  s_axis_tdata,   // [11:0] adc_code
  // stream out
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [TDATA_W-1:0]  m_axis_tdata,   // [11:0] dac_code
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [BANK_W-1:0]   pwdata,
  output logic [BANK_W-1:0]   prdata,
  output logic                pready
);

  coef_t             coef  [TAPS];
  sample_t           tap   [TAPS];
  logic              dl_valid, dl_ready;
  logic              acc_valid, acc_ready;
  acc_t              acc;
  logic [CODE_W-1:0] dac_code;

  // coefficient banks
  fir16_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .coef_o  (coef)
  );

  // newest sample sits in the last tap, oldest in tap zero
  fir16_delay u_delay (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .code_i     (s_axis_tdata[CODE_W-1:0]),
    .valid_o    (dl_valid),
    .ready_i    (dl_ready),
    .tap_o      (tap)
  );

  // sixteen multipliers and a registered adder tree
  fir16_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dl_valid),
    .ready_o (dl_ready),
    .tap_i   (tap),
    .coef_i  (coef),
    .valid_o (acc_valid),
    .ready_i (acc_ready),
    .acc_o   (acc)
  );

  // scaling, saturation and output register
  fir16_out u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (acc_valid),
    .ready_o (acc_ready),
    .acc_i   (acc),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .code_o  (dac_code)
  );

  assign m_axis_tdata = {{(TDATA_W - CODE_W){1'b0}}, dac_code};

endmodule

FILE: hdl/fir16_chk.sv
module fir16_chk
  import fir16_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [TDATA_W-1:0]  m_axis_tdata,
  input logic                psel,
  input logic                penable,
  input logic                pwrite,
  input logic [ADDR_W-1:0]   paddr,
  input logic [BANK_W-1:0]   pwdata,
  input logic [BANK_W-1:0]   prdata,
  input logic                pready
);

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed while stalled");

  // pad bits above the code stay zero
  a_out_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[TDATA_W-1:CODE_W] == '0)
    else $error("output pad bits set");

  // input only stalls when the output side is backed up
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled with output free");

  // a written bank reads back
  a_cfg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && pready) ##1 (paddr == $past(paddr))
      |-> prdata == $past(pwdata))
    else $error("coefficient bank readback mismatch");

endmodule

bind fir_filter_16tap fir16_chk u_chk (.*);

FILE: tb/sv/fir_filter_16tap_test.sv
`timescale 1ns / 100ps

module fir_filter_16tap_test;
  import fir16_pkg::*;

  localparam int NUM_PHASES      = 12;
  localparam int WORDS_PER_PHASE = 155;
  localparam int HOLD_PHASE      = 3;
  localparam int HOLD_CYCLES     = 400;
  localparam int DRAIN_CYCLES    = 8;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int MAX_REPORTS     = 10;
  localparam int NO_TYPED        = -1;
  localparam int DAC_ZERO        = 2048;
  localparam int DAC_TOP         = 4095;
  localparam int DAC_BOTTOM      = 0;

  typedef enum logic {
    STEP_SAMPLE,
    STEP_CFG
  } step_kind_e;

  typedef enum logic [1:0] {
    CM_SMALL,
    CM_WIDE,
    CM_SPARSE,
    CM_FLAT
  } coef_mode_e;

  typedef struct {
    step_kind_e       kind;
    reg_idx_e         idx;
    bank_t            value;
    logic [CODE_W-1:0] code;
    int               dac_exp;
  } dir_step_t;

  // directed table: reset state, both coefficient extremes, clamp at both ends,
  // floor of the shift on a negative sum, newest tap alone
  localparam int DIR_LEN = 25;
  dir_step_t dir_steps [DIR_LEN] = '{
    '{STEP_SAMPLE, REG_COEF_A, 64'h0, 12'h000, DAC_ZERO},
    '{STEP_SAMPLE, REG_COEF_A, 64'h0, 12'hfff, DAC_ZERO},
    '{STEP_SAMPLE, REG_COEF_A, 64'h0, 12'h800, DAC_ZERO},
    '{STEP_SAMPLE, REG_COEF_A, 64'h0, 12'h7ff, DAC_ZERO},
    '{STEP_CFG,    REG_COEF_A, 64'h8000_8000_8000_8000, 12'h000, NO_TYPED},
    '{STEP_CFG,    REG_COEF_B, 64'h8000_8000_8000_8000, 12'h000, NO_TYPED},
    '{STEP_CFG,    REG_COEF_C, 64'h8000_8000_8000_8000, 12'h000, NO_TYPED},
    '{STEP_CFG,    REG_COEF_D, 64'h8000_8000_8000_8000, 12'h000, NO_TYPED},
    '{STEP_SAMPLE, REG_COEF_A, 64'h0, 12'h800, DAC_TOP},
    '{STEP_SAMPLE, REG_COEF_A, 64'h0, 12'h800, DAC_TOP},
    '{STEP_SAMPLE, REG_COEF_A, 64'h0, 12'h7ff, NO_TYPED},
    '{STEP_SAMPLE, REG_COEF_A, 64'h0, 12'h7ff, NO_TYPED},
    '{STEP_SAMPLE, REG_COEF_A, 64'h0, 12'h7ff, NO_TYPED},
    '{STEP_SAMPLE, REG_COEF_A, 64'h0, 12'h7ff, DAC_BOTTOM},
    '{STEP_CFG,    REG_COEF_A, 64'h0, 12'h000, NO_TYPED},
    '{STEP_CFG,    REG_COEF_B, 64'h0, 12'h000, NO_TYPED},
    '{STEP_CFG,    REG_COEF_C, 64'h0, 12'h000, NO_TYPED},
    '{STEP_CFG,    REG_COEF_D, 64'h0001_0000_0000_0000, 12'h000, NO_TYPED},
    '{STEP_SAMPLE, REG_COEF_A, 64'h0, 12'hfff, DAC_ZERO - 1},
    '{STEP_SAMPLE, REG_COEF_A, 64'h0, 12'h001, DAC_ZERO},
    '{STEP_CFG,    REG_COEF_A, 64'h7fff_7fff_7fff_7fff, 12'h000, NO_TYPED},
    '{STEP_CFG,    REG_COEF_D, 64'h7fff_1234_8000_0fcc, 12'h000, NO_TYPED},
    '{STEP_SAMPLE, REG_COEF_A, 64'h0, 12'h555, NO_TYPED},
    '{STEP_SAMPLE, REG_COEF_A, 64'h0, 12'haaa, NO_TYPED},
    '{STEP_SAMPLE, REG_COEF_A, 64'h0, 12'h000, NO_TYPED}
  };

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #5 clk_i = ~clk_i;

  // stream in
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [TDATA_W-1:0] s_axis_tdata  = '0;   // [11:0] adc_code
  // stream out
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [TDATA_W-1:0] m_axis_tdata;         // [11:0] dac_code
  // configuration
  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [ADDR_W-1:0]  paddr   = '0;
  logic [BANK_W-1:0]  pwdata  = '0;
  logic [BANK_W-1:0]  prdata;
  logic               pready;

  fir_filter_16tap dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // filter image: coefficient banks, sample history and its write slot
  bank_t   coef_banks [NUM_BANKS];
  sample_t history [TAPS];
  int      hist_slot;

  logic [CODE_W-1:0] dac_expect_q [$];

  int err_cnt    = 0;
  int words_in   = 0;
  int words_out  = 0;
  int cfg_writes = 0;
  int clamp_hi   = 0;
  int clamp_lo   = 0;

  logic idle_en  = 1'b0;
  logic hold_req = 1'b0;

  function automatic void note_mismatch(input string what, input logic [63:0] want,
                                        input logic [63:0] got);
    err_cnt++;
    if (err_cnt <= MAX_REPORTS)
      $display("mismatch in %s at %0t: expected %0h, got %0h", what, $time, want, got);
  endfunction

  // one filter step: store the new sample, sum oldest to newest tap, then shift, recenter and clamp
  function automatic logic [CODE_W-1:0] filter_step(input logic [CODE_W-1:0] code);
    longint acc;
    longint y;
    int     pos;
    int     j;
    coef_t  c;
    history[hist_slot] = sample_t'(code);
    hist_slot = (hist_slot + 1) % TAPS;
    pos = hist_slot;
    acc = 0;
    for (j = 0; j < TAPS; j++) begin
      c = coef_t'(coef_banks[j / COEF_PER_BANK][COEF_W * (j % COEF_PER_BANK) +: COEF_W]);
      acc += longint'(history[pos]) * longint'(c);
      pos = (pos + 1) % TAPS;
    end
    y = (acc >>> OUT_SHIFT) + DAC_ZERO;
    if (y < DAC_BOTTOM) begin
      y = DAC_BOTTOM;
      clamp_lo++;
    end else if (y > DAC_TOP) begin
      y = DAC_TOP;
      clamp_hi++;
    end
    return CODE_W'(y);
  endfunction

  function automatic logic [CODE_W-1:0] pick_code();
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 3))
        0: return 12'h000;
        1: return 12'h7ff;
        2: return 12'h800;
        default: return 12'hfff;
      endcase
    end
    return CODE_W'($urandom_range(0, 4095));
  endfunction

  function automatic bank_t pick_bank(input coef_mode_e mode, input coef_t flat);
    bank_t b;
    int    k;
    b = '0;
    case (mode)
      CM_WIDE:   b = {$urandom, $urandom};
      CM_FLAT:   b = {COEF_PER_BANK{flat}};
      CM_SPARSE: begin
        if ($urandom_range(0, 3) == 0)
          b[COEF_W * $urandom_range(0, COEF_PER_BANK - 1) +: COEF_W] = COEF_W'($urandom);
      end
      default: begin
        for (k = 0; k < COEF_PER_BANK; k++)
          b[COEF_W * k +: COEF_W] = COEF_W'($urandom_range(0, 8191) - 4096);
      end
    endcase
    return b;
  endfunction

  // write one bank, read it back, then leave the bus idle
  task automatic program_bank(input reg_idx_e idx, input bank_t value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(idx) << IDX_LSB;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    coef_banks[idx] = value;
    cfg_writes++;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== value) note_mismatch("bank readback", value, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // offer one word until taken; predict on acceptance; idle now and then when idle_en is set
  task automatic send_word(input logic [CODE_W-1:0] code, input int typed);
    logic [CODE_W-1:0] want;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= TDATA_W'(code);
    do @(posedge clk_i); while (!s_axis_tready);
    want = filter_step(code);
    if (typed != NO_TYPED) want = CODE_W'(typed);
    dac_expect_q.push_back(want);
    words_in++;
    if (idle_en && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
  endtask

  // stop offering and wait until every expected word is back
  task automatic drain_pipe();
    s_axis_tvalid <= 1'b0;
    while (dac_expect_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // sink: random stall bursts, plus one long hold on request
  int sink_gap  = 0;
  int hold_left = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (hold_req && hold_left == 0) begin
        hold_left = HOLD_CYCLES;
        hold_req <= 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (sink_gap != 0) begin
        sink_gap--;
        m_axis_tready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        sink_gap = $urandom_range(1, 18) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // output check against the oldest expectation
  logic [CODE_W-1:0] dac_want;

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      words_out++;
      if (dac_expect_q.size() == 0) begin
        note_mismatch("unexpected dac word", '0, m_axis_tdata[CODE_W-1:0]);
      end else begin
        dac_want = dac_expect_q.pop_front();
        if (m_axis_tdata[CODE_W-1:0] !== dac_want)
          note_mismatch("dac_code", dac_want, m_axis_tdata[CODE_W-1:0]);
      end
    end
  end

  // watchdog on cycles without any transfer
  int quiet_cycles = 0;

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int         i;
    int         p;
    int         n;
    coef_mode_e mode;
    coef_t      flat;
    for (i = 0; i < NUM_BANKS; i++) coef_banks[i] = '0;
    for (i = 0; i < TAPS; i++) history[i] = '0;
    hist_slot = 0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part
    idle_en <= 1'b1;
    for (i = 0; i < DIR_LEN; i++) begin
      if (dir_steps[i].kind == STEP_CFG) begin
        drain_pipe();
        program_bank(dir_steps[i].idx, dir_steps[i].value);
      end else begin
        send_word(dir_steps[i].code, dir_steps[i].dac_exp);
      end
    end

    // random phases, each under a fresh coefficient set
    for (p = 0; p < NUM_PHASES; p++) begin
      drain_pipe();
      if (p == NUM_PHASES - 1) idle_en <= 1'b0;
      else idle_en <= (p == 0) || ($urandom_range(0, 3) != 0);
      flat = '0;
      if (p == 1) begin
        mode = CM_FLAT;
        flat = 16'sh7fff;
      end else if (p == 2) begin
        mode = CM_FLAT;
        flat = 16'sh8000;
      end else begin
        n = $urandom_range(0, 9);
        mode = (n < 6) ? CM_SMALL : (n < 8) ? CM_SPARSE : CM_WIDE;
      end
      for (i = 0; i < NUM_BANKS; i++)
        program_bank(reg_idx_e'(i), pick_bank(mode, flat));
      if (p == HOLD_PHASE) hold_req <= 1'b1;
      for (i = 0; i < WORDS_PER_PHASE; i++)
        send_word(pick_code(), NO_TYPED);
    end

    drain_pipe();

    $display("covered %0d words in, %0d words out, %0d bank writes over %0d settings",
             words_in, words_out, cfg_writes, NUM_PHASES + 3);
    $display("clamped high %0d times, low %0d times; mismatches %0d",
             clamp_hi, clamp_lo, err_cnt);
    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
